// File: rtl/core/flash_setting_log_wear_leveler_top_defines.svh
// Assertion macros shared by the settings log checker.
`ifndef FLASH_SETTING_LOG_WEAR_LEVELER_TOP_DEFINES_SVH
`define FLASH_SETTING_LOG_WEAR_LEVELER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSLWL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FSLWL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/fslwl_pkg.sv
// Types and constants for the settings log with wear levelling.
package fslwl_pkg;

    localparam int DATA_W   = 16;
    localparam int SEL_W    = 2;
    localparam int REQ_W    = 3;
    localparam int IDX_W    = 9;
    localparam int POS_W    = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [DATA_W-1:0] ERASED_WORD     = 16'hFFFF;
    localparam logic [DATA_W-1:0] ENTRY_HIGH_MASK = 16'hFF00;
    localparam logic [DATA_W-1:0] SETTLE_TICKS_RST = 16'd3000;
    localparam logic [SEL_W-1:0]  DEFAULT_SEL_RST  = 2'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETTLE_TICKS = 1'b0,
        CFG_DEFAULT_SEL  = 1'b1
    } t_cfg_idx;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK    = 3'd0,
        REQ_CHANGE  = 3'd1,
        REQ_SAVE    = 3'd2,
        REQ_RESTORE = 3'd3,
        REQ_PRELOAD = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHK0,
        ST_SCAN,
        ST_ERASE,
        ST_WIPE,
        ST_WIPE_END
    } t_state;

    typedef struct packed {
        logic exec;
        logic addr_clr;
        logic addr_one;
        logic addr_inc;
        logic sweep_we;
        logic sweep_chk;
        logic restore_def;
        logic scan_hold;
        logic scan_end_bad;
        logic scan_end_last;
        logic res_valid;
        logic res_wrote;
        logic res_erased;
        logic res_use_dirty;
    } t_dp_cmd;

    typedef struct packed {
        logic save_ok;
        logic log_full;
        logic slot_bad;
        logic at_last;
    } t_dp_stat;

endpackage

// File: rtl/core/fslwl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fslwl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // read returns the old contents when the same address is written
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/fslwl_ctrl.sv
// Sequencer for requests, page sweeps and restore scans.
module fslwl_ctrl
    import fslwl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [REQ_W-1:0] i_req_type,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd,
    output logic             o_busy
);

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_stat.at_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) begin
                    case (t_req'(i_req_type))
                        REQ_RESTORE: n_state = ST_CHK0;
                        REQ_SAVE: begin
                            if (i_stat.save_ok && i_stat.log_full) n_state = ST_ERASE;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CHK0: begin
                n_state = i_stat.slot_bad ? ST_WIPE : ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.slot_bad || i_stat.at_last) n_state = ST_IDLE;
            end
            ST_ERASE: begin
                if (i_stat.at_last) n_state = ST_IDLE;
            end
            ST_WIPE: begin
                if (i_stat.at_last) n_state = ST_WIPE_END;
            end
            ST_WIPE_END: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_cmd = '0;
        case (r_state)
            ST_INIT: begin
                w_cmd.sweep_we = 1'b1;
                w_cmd.addr_clr = i_stat.at_last;
                w_cmd.addr_inc = !i_stat.at_last;
            end
            ST_IDLE: begin
                if (i_start) begin
                    w_cmd.exec = 1'b1;
                    case (t_req'(i_req_type))
                        REQ_RESTORE: w_cmd.addr_clr = 1'b1;
                        REQ_SAVE: begin
                            if (i_stat.save_ok && i_stat.log_full) begin
                                w_cmd.addr_clr = 1'b1;
                            end else begin
                                w_cmd.res_valid = 1'b1;
                                w_cmd.res_wrote = i_stat.save_ok;
                            end
                        end
                        default: w_cmd.res_valid = 1'b1;
                    endcase
                end
            end
            ST_CHK0: begin
                if (i_stat.slot_bad) begin
                    w_cmd.restore_def = 1'b1;
                    w_cmd.addr_clr    = 1'b1;
                end else begin
                    w_cmd.scan_hold = 1'b1;
                    w_cmd.addr_one  = 1'b1;
                end
            end
            ST_SCAN: begin
                if (i_stat.slot_bad) begin
                    w_cmd.scan_end_bad = 1'b1;
                    w_cmd.res_valid    = 1'b1;
                end else if (i_stat.at_last) begin
                    w_cmd.scan_end_last = 1'b1;
                    w_cmd.res_valid     = 1'b1;
                end else begin
                    w_cmd.scan_hold = 1'b1;
                    w_cmd.addr_inc  = 1'b1;
                end
            end
            ST_ERASE: begin
                w_cmd.sweep_we = 1'b1;
                if (i_stat.at_last) begin
                    w_cmd.addr_clr   = 1'b1;
                    w_cmd.res_valid  = 1'b1;
                    w_cmd.res_wrote  = 1'b1;
                    w_cmd.res_erased = 1'b1;
                end else begin
                    w_cmd.addr_inc = 1'b1;
                end
            end
            ST_WIPE: begin
                w_cmd.sweep_we  = 1'b1;
                w_cmd.sweep_chk = 1'b1;
                w_cmd.addr_clr  = i_stat.at_last;
                w_cmd.addr_inc  = !i_stat.at_last;
            end
            ST_WIPE_END: begin
                w_cmd.res_valid     = 1'b1;
                w_cmd.res_wrote     = 1'b1;
                w_cmd.res_use_dirty = 1'b1;
            end
            default: w_cmd = '0;
        endcase
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != ST_IDLE);

endmodule

// File: rtl/core/fslwl_dp.sv
// Selection state, settle countdown, log page and result register.
module fslwl_dp
    import fslwl_pkg::*;
#(
    parameter int LOG_WORDS = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [SEL_W-1:0]     i_new_selection,
    input  logic [IDX_W-1:0]     i_word_index,
    input  logic [DATA_W-1:0]    i_word_value,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic                 o_done,
    output logic [SEL_W-1:0]     o_selected_input,
    output logic [SEL_W-1:0]     o_saved_input,
    output logic [POS_W-1:0]     o_log_position,
    output logic                 o_did_write,
    output logic                 o_did_erase,
    output logic                 o_save_pending
);

    localparam int AW = $clog2(LOG_WORDS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(LOG_WORDS - 1);

    logic [AW-1:0]     r_addr, n_addr;
    logic [SEL_W-1:0]  r_cur, n_cur;
    logic [SEL_W-1:0]  r_saved, n_saved;
    logic [AW-1:0]     r_newest, n_newest;
    logic [DATA_W-1:0] r_settle, n_settle;
    logic [DATA_W-1:0] r_settle_ticks;
    logic [SEL_W-1:0]  r_default_sel;
    logic [DATA_W-1:0] r_fill0, n_fill0;
    logic [SEL_W-1:0]  r_prev_sel, n_prev_sel;
    logic              r_chk_pend;
    logic              r_dirty, n_dirty;

    logic              r_res_valid;
    logic [SEL_W-1:0]  r_res_cur, r_res_saved;
    logic [POS_W-1:0]  r_res_pos;
    logic              r_res_wrote, r_res_erased, r_res_pending;

    logic              w_we;
    logic [AW-1:0]     w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;
    logic [AW-1:0]     w_rd_addr;
    logic [DATA_W-1:0] w_rd_data;
    logic              w_save_ok;
    logic              w_log_full;
    logic              w_preload_ok;
    logic              w_dirty_now;
    logic [31:0]       w_idx_ext;
    logic [31:0]       w_pos_ext;

    assign w_idx_ext    = 32'(i_word_index);
    assign w_preload_ok = (w_idx_ext < LOG_WORDS);
    assign w_save_ok    = (r_settle == '0) && (r_cur != r_saved);
    assign w_log_full   = (r_newest == LAST_SLOT);
    assign w_dirty_now  = r_dirty || (r_chk_pend && (w_rd_data != ERASED_WORD));

    assign o_stat.save_ok  = w_save_ok;
    assign o_stat.log_full = w_log_full;
    assign o_stat.slot_bad = ((w_rd_data & ENTRY_HIGH_MASK) != '0);
    assign o_stat.at_last  = (r_addr == LAST_SLOT);

    always_comb begin
        if (i_cmd.addr_clr)      n_addr = '0;
        else if (i_cmd.addr_one) n_addr = AW'(1);
        else if (i_cmd.addr_inc) n_addr = r_addr + AW'(1);
        else                     n_addr = r_addr;
    end

    // a sweep reads the slot it overwrites, so the old word can be checked
    assign w_rd_addr = i_cmd.sweep_we ? r_addr : n_addr;

    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = r_addr;
        w_wr_data = ERASED_WORD;
        if (i_cmd.sweep_we) begin
            w_we      = 1'b1;
            w_wr_addr = r_addr;
            w_wr_data = (r_addr == '0) ? r_fill0 : ERASED_WORD;
        end else if (i_cmd.exec) begin
            case (t_req'(i_req_type))
                REQ_SAVE: begin
                    w_we      = w_save_ok && !w_log_full;
                    w_wr_addr = r_newest + AW'(1);
                    w_wr_data = DATA_W'(r_cur);
                end
                REQ_PRELOAD: begin
                    w_we      = w_preload_ok;
                    w_wr_addr = w_idx_ext[AW-1:0];
                    w_wr_data = i_word_value;
                end
                default: w_we = 1'b0;
            endcase
        end
    end

    fslwl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LOG_WORDS)
    ) u_log_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_cur      = r_cur;
        n_saved    = r_saved;
        n_newest   = r_newest;
        n_settle   = r_settle;
        n_fill0    = r_fill0;
        n_prev_sel = r_prev_sel;
        n_dirty    = w_dirty_now;
        if (i_cmd.exec) begin
            n_dirty = 1'b0;
            case (t_req'(i_req_type))
                REQ_TICK: begin
                    if (r_settle != '0) n_settle = r_settle - DATA_W'(1);
                end
                REQ_CHANGE: begin
                    n_cur    = i_new_selection;
                    n_settle = r_settle_ticks;
                end
                REQ_SAVE: begin
                    if (w_save_ok) begin
                        n_saved = r_cur;
                        if (w_log_full) begin
                            n_newest = '0;
                            n_fill0  = DATA_W'(r_cur);
                        end else begin
                            n_newest = r_newest + AW'(1);
                        end
                    end
                end
                default: n_settle = r_settle;
            endcase
        end
        if (i_cmd.restore_def) begin
            n_cur    = r_default_sel;
            n_saved  = r_default_sel;
            n_newest = '0;
            n_fill0  = DATA_W'(r_default_sel);
        end
        if (i_cmd.scan_hold) n_prev_sel = w_rd_data[SEL_W-1:0];
        if (i_cmd.scan_end_bad) begin
            n_newest = r_addr - AW'(1);
            n_cur    = r_prev_sel;
            n_saved  = r_prev_sel;
        end
        if (i_cmd.scan_end_last) begin
            n_newest = r_addr;
            n_cur    = w_rd_data[SEL_W-1:0];
            n_saved  = w_rd_data[SEL_W-1:0];
        end
    end

    assign w_pos_ext = 32'(n_newest);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr         <= '0;
            r_cur          <= '0;
            r_saved        <= '0;
            r_newest       <= '0;
            r_settle       <= '0;
            r_settle_ticks <= SETTLE_TICKS_RST;
            r_default_sel  <= DEFAULT_SEL_RST;
            r_fill0        <= ERASED_WORD;
            r_chk_pend     <= 1'b0;
            r_dirty        <= 1'b0;
            r_res_valid    <= 1'b0;
        end else begin
            r_addr      <= n_addr;
            r_cur       <= n_cur;
            r_saved     <= n_saved;
            r_newest    <= n_newest;
            r_settle    <= n_settle;
            r_fill0     <= n_fill0;
            r_chk_pend  <= i_cmd.sweep_chk;
            r_dirty     <= n_dirty;
            r_res_valid <= i_cmd.res_valid;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SETTLE_TICKS: r_settle_ticks <= i_cfg_data;
                    CFG_DEFAULT_SEL:  r_default_sel  <= i_cfg_data[SEL_W-1:0];
                    default:          r_settle_ticks <= r_settle_ticks;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev_sel <= n_prev_sel;
        if (i_cmd.res_valid) begin
            r_res_cur     <= n_cur;
            r_res_saved   <= n_saved;
            r_res_pos     <= w_pos_ext[POS_W-1:0];
            r_res_wrote   <= i_cmd.res_wrote;
            r_res_erased  <= i_cmd.res_erased || (i_cmd.res_use_dirty && w_dirty_now);
            r_res_pending <= (n_cur != n_saved);
        end
    end

    assign o_done           = r_res_valid;
    assign o_selected_input = r_res_cur;
    assign o_saved_input    = r_res_saved;
    assign o_log_position   = r_res_pos;
    assign o_did_write      = r_res_wrote;
    assign o_did_erase      = r_res_erased;
    assign o_save_pending   = r_res_pending;

endmodule

// File: rtl/core/flash_setting_log_wear_leveler_top.sv
// Top level of the settings log with wear levelling.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------------
//  request   | i_start, o_busy    | i_req_type, i_new_selection, i_word_index,
//            |                    | i_word_value
//  result    | o_done (strobe)    | o_selected_input, o_saved_input,
//            |                    | o_log_position, o_did_write, o_did_erase,
//            |                    | o_save_pending
//  config    | i_cfg_we           | i_cfg_idx, i_cfg_data
//
//  Tick, change, preload, plain save and unknown requests: result in the cycle after accept.
//  Save into a full log: result after the page erase, which clears one slot a cycle.
//  Restore: on a valid page the scan reads one slot a cycle through the RAM read port;
//  on an invalid page a check-and-erase sweep of the page runs before the result.
//  After reset the page is cleared with o_busy high.
//  Results are strobed for one cycle; the receiver cannot stall.
module flash_setting_log_wear_leveler_top
    import fslwl_pkg::*;
#(
    parameter int LOG_WORDS = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [SEL_W-1:0]     i_new_selection,
    input  logic [IDX_W-1:0]     i_word_index,
    input  logic [DATA_W-1:0]    i_word_value,
    output logic                 o_done,
    output logic [SEL_W-1:0]     o_selected_input,
    output logic [SEL_W-1:0]     o_saved_input,
    output logic [POS_W-1:0]     o_log_position,
    output logic                 o_did_write,
    output logic                 o_did_erase,
    output logic                 o_save_pending
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    fslwl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (o_busy)
    );

    fslwl_dp #(
        .LOG_WORDS (LOG_WORDS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_req_type       (i_req_type),
        .i_new_selection  (i_new_selection),
        .i_word_index     (i_word_index),
        .i_word_value     (i_word_value),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_done           (o_done),
        .o_selected_input (o_selected_input),
        .o_saved_input    (o_saved_input),
        .o_log_position   (o_log_position),
        .o_did_write      (o_did_write),
        .o_did_erase      (o_did_erase),
        .o_save_pending   (o_save_pending)
    );

endmodule

// File: rtl/core/fslwl_checker.sv
// Port-level checks for the settings log, bound to the top level.
`include "flash_setting_log_wear_leveler_top_defines.svh"

module fslwl_checker
    import fslwl_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_start,
    input logic                 o_busy,
    input logic [REQ_W-1:0]     i_req_type,
    input logic                 o_done,
    input logic [POS_W-1:0]     o_log_position,
    input logic                 o_did_write,
    input logic                 o_did_erase
);

    // restore always goes through at least one slot read
    `FSLWL_ASSERT_NEXT(a_restore_busy, i_clk, i_rst_n,
        i_start && !o_busy && (i_req_type == REQ_RESTORE), o_busy,
        "restore request did not raise busy")

    // requests that never walk the page answer on the next cycle
    `FSLWL_ASSERT_NEXT(a_quick_result, i_clk, i_rst_n,
        i_start && !o_busy && (i_req_type != REQ_SAVE) && (i_req_type != REQ_RESTORE),
        o_done, "single-cycle request gave no result")

    `FSLWL_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !o_busy,
        "result strobed while still busy")

    // an erase always ends with a fresh entry in slot zero
    `FSLWL_ASSERT_NOW(a_erase_slot0, i_clk, i_rst_n, o_done && o_did_erase,
        o_did_write && (o_log_position == '0), "erase without a write to slot zero")

endmodule

bind flash_setting_log_wear_leveler_top fslwl_checker u_fslwl_checker (.*);

// File: verif/tb_flash_setting_log_wear_leveler_top.sv
// Self-checking testbench for the wear-levelled settings log: directed cases, page wrap, random traffic.
module tb_flash_setting_log_wear_leveler_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fslwl_pkg::*;

    localparam int LOG_WORDS = 512;
    localparam int STALL_MAX = 10;
    localparam int MAX_PRINTED_ERRORS = 200;
    // request codes the block does not decode
    localparam logic [REQ_W-1:0] REQ_RSVD_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic [SEL_W-1:0] selected;
        logic [SEL_W-1:0] saved;
        logic [POS_W-1:0] position;
        logic             wrote;
        logic             erased;
        logic             pending;
    } t_log_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0]    i_cfg_data;
    logic                 i_start;
    logic                 o_busy;
    logic [REQ_W-1:0]     i_req_type;
    logic [SEL_W-1:0]     i_new_selection;
    logic [IDX_W-1:0]     i_word_index;
    logic [DATA_W-1:0]    i_word_value;
    logic                 o_done;
    logic [SEL_W-1:0]     o_selected_input;
    logic [SEL_W-1:0]     o_saved_input;
    logic [POS_W-1:0]     o_log_position;
    logic                 o_did_write;
    logic                 o_did_erase;
    logic                 o_save_pending;

    // shadow of the flash page and selection state
    logic [DATA_W-1:0] page_q [LOG_WORDS];
    logic [SEL_W-1:0]  cur_sel_q;
    logic [SEL_W-1:0]  saved_sel_q;
    logic [SEL_W-1:0]  dflt_sel_q;
    logic [POS_W-1:0]  newest_q;
    logic [DATA_W-1:0] settle_left_q;
    logic [DATA_W-1:0] settle_ticks_q;

    t_log_result pending_results [$];
    int unsigned requests_sent;
    int unsigned appends_predicted;
    int unsigned erases_predicted;
    int unsigned restores_sent;
    int unsigned error_count;
    bit          idle_gaps;

    flash_setting_log_wear_leveler_top #(
        .LOG_WORDS(LOG_WORDS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_req_type      (i_req_type),
        .i_new_selection (i_new_selection),
        .i_word_index    (i_word_index),
        .i_word_value    (i_word_value),
        .o_done          (o_done),
        .o_selected_input(o_selected_input),
        .o_saved_input   (o_saved_input),
        .o_log_position  (o_log_position),
        .o_did_write     (o_did_write),
        .o_did_erase     (o_did_erase),
        .o_save_pending  (o_save_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #25_000_000;
        $display("tb_flash_setting_log_wear_leveler_top failed");
        $finish;
    end

    task automatic log_error(string msg);
        if (error_count < MAX_PRINTED_ERRORS)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void wipe_page();
        for (int k = 0; k < LOG_WORDS; k++)
            page_q[k] = ERASED_WORD;
    endfunction

    function automatic void model_reset();
        wipe_page();
        cur_sel_q      = '0;
        saved_sel_q    = '0;
        newest_q       = '0;
        settle_left_q  = '0;
        settle_ticks_q = SETTLE_TICKS_RST;
        dflt_sel_q     = DEFAULT_SEL_RST;
    endfunction

    function automatic t_log_result apply_request(logic [REQ_W-1:0] req, logic [SEL_W-1:0] sel,
                                                  logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        t_log_result res;
        int unsigned nxt;
        int unsigned k;
        logic        wrote;
        logic        erased;
        logic        dirty;
        wrote  = 1'b0;
        erased = 1'b0;
        case (req)
            REQ_TICK: begin
                if (settle_left_q != '0)
                    settle_left_q = settle_left_q - 1'b1;
            end
            REQ_CHANGE: begin
                cur_sel_q     = sel;
                settle_left_q = settle_ticks_q;
            end
            REQ_SAVE: begin
                if (settle_left_q == '0 && cur_sel_q != saved_sel_q) begin
                    nxt = int'(newest_q) + 1;
                    saved_sel_q = cur_sel_q;
                    if (nxt >= LOG_WORDS) begin
                        nxt = 0;
                        wipe_page();
                        erased = 1'b1;
                    end
                    newest_q    = POS_W'(nxt);
                    page_q[nxt] = DATA_W'(cur_sel_q);
                    wrote       = 1'b1;
                end
            end
            REQ_RESTORE: begin
                if ((page_q[0] & ENTRY_HIGH_MASK) != '0) begin
                    // no usable log: wipe only if something was programmed
                    dirty = 1'b0;
                    for (k = 0; k < LOG_WORDS; k++)
                        if (page_q[k] != ERASED_WORD)
                            dirty = 1'b1;
                    if (dirty) begin
                        wipe_page();
                        erased = 1'b1;
                    end
                    page_q[0]   = DATA_W'(dflt_sel_q);
                    newest_q    = '0;
                    saved_sel_q = dflt_sel_q;
                    cur_sel_q   = dflt_sel_q;
                    wrote       = 1'b1;
                end else begin
                    k = 1;
                    while (k < LOG_WORDS && (page_q[k] & ENTRY_HIGH_MASK) == '0)
                        k++;
                    newest_q    = POS_W'(k - 1);
                    saved_sel_q = page_q[k - 1][SEL_W-1:0];
                    cur_sel_q   = saved_sel_q;
                end
            end
            REQ_PRELOAD: begin
                if (int'(idx) < LOG_WORDS)
                    page_q[idx] = val;
            end
            default: ;
        endcase
        res.selected = cur_sel_q;
        res.saved    = saved_sel_q;
        res.position = newest_q;
        res.wrote    = wrote;
        res.erased   = erased;
        res.pending  = (cur_sel_q != saved_sel_q);
        return res;
    endfunction

    // Entered and left at a falling edge; i_start stays high for back-to-back requests.
    task automatic send_request(logic [REQ_W-1:0] req, logic [SEL_W-1:0] sel,
                                logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        t_log_result want;
        if (idle_gaps && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, STALL_MAX)) @(negedge i_clk);
        end
        i_start         <= 1'b1;
        i_req_type      <= req;
        i_new_selection <= sel;
        i_word_index    <= idx;
        i_word_value    <= val;
        @(posedge i_clk);
        while (o_busy !== 1'b0)
            @(posedge i_clk);
        want = apply_request(req, sel, idx, val);
        pending_results.push_back(want);
        requests_sent++;
        if (want.wrote)
            appends_predicted++;
        if (want.erased)
            erases_predicted++;
        if (req == REQ_RESTORE)
            restores_sent++;
        @(negedge i_clk);
    endtask

    // unused fields carry random values
    task automatic send_kind(logic [REQ_W-1:0] req, logic [SEL_W-1:0] sel);
        send_request(req, sel, IDX_W'($urandom), DATA_W'($urandom));
    endtask

    task automatic release_bus();
        i_start <= 1'b0;
    endtask

    task automatic wait_results();
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic reconfigure(logic [DATA_W-1:0] settle, logic [SEL_W-1:0] dflt);
        release_bus();
        wait_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SETTLE_TICKS;
        i_cfg_data <= settle;
        @(negedge i_clk);
        settle_ticks_q = settle;
        i_cfg_idx  <= CFG_DEFAULT_SEL;
        i_cfg_data <= DATA_W'(dflt);
        @(negedge i_clk);
        dflt_sel_q = dflt;
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_log_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                log_error("result strobe with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                if (o_selected_input !== want.selected)
                    log_error($sformatf("selected_input %0d, expected %0d",
                                        o_selected_input, want.selected));
                if (o_saved_input !== want.saved)
                    log_error($sformatf("saved_input %0d, expected %0d",
                                        o_saved_input, want.saved));
                if (o_log_position !== want.position)
                    log_error($sformatf("log_position %0d, expected %0d",
                                        o_log_position, want.position));
                if (o_did_write !== want.wrote)
                    log_error($sformatf("did_write %b, expected %b", o_did_write, want.wrote));
                if (o_did_erase !== want.erased)
                    log_error($sformatf("did_erase %b, expected %b", o_did_erase, want.erased));
                if (o_save_pending !== want.pending)
                    log_error($sformatf("save_pending %b, expected %b",
                                        o_save_pending, want.pending));
            end
        end
    end

    task automatic test_basic_requests();
        idle_gaps = 1'b0;
        reconfigure(16'd0, 2'd2);
        send_kind(REQ_TICK, 2'd0);
        send_kind(REQ_SAVE, 2'd0);             // nothing changed, nothing to save
        send_kind(REQ_CHANGE, 2'd1);
        send_kind(REQ_SAVE, 2'd0);             // no restore yet: lands in slot 1
        for (int r = REQ_RSVD_FIRST; r <= REQ_RSVD_LAST; r++)
            send_request(REQ_W'(r), '1, '1, '1);
        send_request(REQ_RESTORE, '0, '0, '0); // slot 0 blank, slot 1 used: erase then default
        send_request(REQ_PRELOAD, 2'd3, '0, ERASED_WORD);
        send_kind(REQ_RESTORE, 2'd1);          // blank page: default only, no erase
        reconfigure(16'd1, 2'd3);
        send_kind(REQ_CHANGE, 2'd3);
        send_kind(REQ_SAVE, 2'd3);             // still settling
        send_kind(REQ_TICK, 2'd2);
        send_kind(REQ_TICK, 2'd0);             // countdown holds at zero
        send_kind(REQ_SAVE, 2'd1);
        send_request(REQ_PRELOAD, 2'd0, '1, 16'h0000);
        send_request(REQ_PRELOAD, 2'd0, 9'd2, 16'h00FE);
        send_kind(REQ_RESTORE, 2'd0);          // newest entry is the preloaded one
        reconfigure(16'hFFFF, 2'd0);
        send_kind(REQ_CHANGE, 2'd0);
        send_kind(REQ_TICK, 2'd3);
        send_kind(REQ_TICK, 2'd1);
        send_kind(REQ_SAVE, 2'd2);             // long settle time: refused
        send_request(REQ_PRELOAD, 2'd1, '0, 16'h0100);
        send_kind(REQ_RESTORE, 2'd3);          // corrupt slot 0
    endtask

    // Fill the page by preload, then append across the end of the log.
    task automatic test_page_wrap();
        reconfigure(16'd0, 2'd1);
        idle_gaps = 1'b1;
        send_request(REQ_PRELOAD, 2'($urandom), IDX_W'(LOG_WORDS - 1), ERASED_WORD);
        for (int k = 0; k < LOG_WORDS - 1; k++)
            send_request(REQ_PRELOAD, 2'($urandom), IDX_W'(k), {8'h00, 8'($urandom)});
        send_kind(REQ_RESTORE, 2'($urandom));
        repeat (2) begin
            send_kind(REQ_CHANGE, saved_sel_q ^ 2'($urandom_range(1, 3)));
            send_kind(REQ_SAVE, 2'($urandom));
            send_kind(REQ_RESTORE, 2'($urandom));
        end
    endtask

    task automatic test_random_traffic(logic [DATA_W-1:0] settle, logic [SEL_W-1:0] dflt,
                                       int unsigned n_items, bit gaps);
        int unsigned      stop_at;
        int unsigned      pick;
        int unsigned      ticks;
        logic [IDX_W-1:0] slot;
        logic [DATA_W-1:0] word;
        reconfigure(settle, dflt);
        stop_at = requests_sent + n_items;
        while (requests_sent < stop_at) begin
            idle_gaps = gaps && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                // change, settle, save: mostly a real change with the right tick count
                if ($urandom_range(0, 4) == 0)
                    send_kind(REQ_CHANGE, 2'($urandom));
                else
                    send_kind(REQ_CHANGE, saved_sel_q ^ 2'($urandom_range(1, 3)));
                if (settle_ticks_q > 8)
                    ticks = $urandom_range(0, 3);
                else if ($urandom_range(0, 5) == 0)
                    ticks = $urandom_range(0, settle_ticks_q);
                else
                    ticks = settle_ticks_q + $urandom_range(0, 1);
                repeat (ticks) send_kind(REQ_TICK, 2'($urandom));
                send_kind(REQ_SAVE, 2'($urandom));
            end else if (pick < 73) begin
                send_kind(REQ_W'($urandom_range(REQ_TICK, REQ_SAVE)), 2'($urandom));
            end else if (pick < 78) begin
                send_kind(REQ_RESTORE, 2'($urandom));
            end else if (pick < 95) begin
                case ($urandom_range(0, 9))
                    0, 1:    slot = '0;
                    2, 3, 4: slot = IDX_W'($urandom);
                    default: slot = newest_q + 1'b1;
                endcase
                case ($urandom_range(0, 3))
                    0:       word = ERASED_WORD;
                    1:       word = DATA_W'($urandom);
                    default: word = {8'h00, 8'($urandom)};
                endcase
                send_request(REQ_PRELOAD, 2'($urandom), slot, word);
            end else begin
                send_kind(REQ_W'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST)), 2'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_SETTLE_TICKS;
        i_cfg_data      <= '0;
        i_start         <= 1'b0;
        i_req_type      <= REQ_TICK;
        i_new_selection <= '0;
        i_word_index    <= '0;
        i_word_value    <= '0;
        idle_gaps       = 1'b0;
        model_reset();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // page clear after reset keeps the block busy
        @(posedge i_clk);
        while (o_busy !== 1'b0)
            @(posedge i_clk);
        @(negedge i_clk);

        test_basic_requests();
        test_page_wrap();
        test_random_traffic(16'd0, 2'd3, 140, 1'b1);
        test_random_traffic(16'd1, 2'd0, 140, 1'b1);
        test_random_traffic(16'd2, 2'd1, 140, 1'b1);
        test_random_traffic(DATA_W'($urandom_range(0, 4)), 2'($urandom), 140, 1'b0);

        release_bus();
        wait_results();
        repeat (LOG_WORDS + 8) @(negedge i_clk);
        $display("Ran %0d requests (%0d restore scans) through the settings log.",
                 requests_sent, restores_sent);
        $display("Log appends seen: %0d, page erases seen: %0d, mismatches: %0d.",
                 appends_predicted, erases_predicted, error_count);
        if (error_count == 0)
            $display("tb_flash_setting_log_wear_leveler_top passed");
        else
            $display("tb_flash_setting_log_wear_leveler_top failed");
        $finish;
    end

endmodule

// File: flash_setting_log_wear_leveler_top.f
+incdir+rtl/core
rtl/core/fslwl_pkg.sv
rtl/core/fslwl_ram.sv
rtl/core/fslwl_ctrl.sv
rtl/core/fslwl_dp.sv
rtl/core/flash_setting_log_wear_leveler_top.sv
rtl/core/fslwl_checker.sv
verif/tb_flash_setting_log_wear_leveler_top.sv
